/* rtl/pqls_pkg.sv */
// ----------------------------------------------------------------------------
// pqls_pkg
// Shared types and codes for the linear-scan priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pqls_pkg;

	localparam int DATA_W = 32;
	localparam int OCC_W  = 5;

	localparam logic FUNC_INSERT  = 1'b0;
	localparam logic FUNC_EXTRACT = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic shift;
	} pqls_ctrl_t;

	// running best handed from cell to cell during an extract scan
	typedef struct packed {
		logic                     go;
		logic                     found;
		logic signed [DATA_W-1:0] pri;
		logic signed [DATA_W-1:0] val;
	} pqls_scan_t;

endpackage

`default_nettype wire

/* rtl/pqls_cell.sv */
// ----------------------------------------------------------------------------
// pqls_cell
// One queue slot: holds a (value, priority) pair, appends at the tail,
// compares against the running best on scan and shifts down on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module pqls_cell #(
	parameter int IW    = 4,
	parameter int INDEX = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pqls_pkg::pqls_ctrl_t              ctrl,
	input  logic [IW-1:0]                     shift_idx,
	input  logic signed [pqls_pkg::DATA_W-1:0] in_value,
	input  logic signed [pqls_pkg::DATA_W-1:0] in_priority,
	input  logic                              prev_valid,
	input  logic                              next_valid,
	input  logic signed [pqls_pkg::DATA_W-1:0] next_value,
	input  logic signed [pqls_pkg::DATA_W-1:0] next_priority,
	input  pqls_pkg::pqls_scan_t              scan_in,
	input  logic [IW-1:0]                     scan_in_idx,
	output pqls_pkg::pqls_scan_t              scan_out,
	output logic [IW-1:0]                     scan_out_idx,
	output logic                              valid,
	output logic signed [pqls_pkg::DATA_W-1:0] value,
	output logic signed [pqls_pkg::DATA_W-1:0] prio
);
	import pqls_pkg::*;

	logic                     valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic signed [DATA_W-1:0] priority_q;
	logic                     scan_go_q;
	logic                     scan_found_q;
	logic signed [DATA_W-1:0] scan_pri_q;
	logic signed [DATA_W-1:0] scan_val_q;
	logic [IW-1:0]            scan_idx_q;
	logic                     wr_en;
	logic                     sh_en;
	logic                     take;

	assign wr_en = ctrl.ins && !valid_q && prev_valid;
	assign sh_en = ctrl.shift && (shift_idx <= IW'(INDEX));
	assign take  = valid_q && (!scan_in.found || ($signed(priority_q) > $signed(scan_in.pri)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			scan_go_q <= 1'b0;
		end else begin
			scan_go_q <= scan_in.go;
			if (sh_en) begin
				valid_q <= next_valid;
			end else if (wr_en) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sh_en) begin
			value_q    <= next_value;
			priority_q <= next_priority;
		end else if (wr_en) begin
			value_q    <= in_value;
			priority_q <= in_priority;
		end
		if (scan_in.go) begin
			if (take) begin
				scan_found_q <= 1'b1;
				scan_pri_q   <= priority_q;
				scan_val_q   <= value_q;
				scan_idx_q   <= IW'(INDEX);
			end else begin
				scan_found_q <= scan_in.found;
				scan_pri_q   <= scan_in.pri;
				scan_val_q   <= scan_in.val;
				scan_idx_q   <= scan_in_idx;
			end
		end
	end

	always_comb begin
		scan_out.go    = scan_go_q;
		scan_out.found = scan_found_q;
		scan_out.pri   = scan_pri_q;
		scan_out.val   = scan_val_q;
	end

	assign scan_out_idx = scan_idx_q;
	assign valid        = valid_q;
	assign value        = value_q;
	assign prio         = priority_q;

endmodule

`default_nettype wire

/* rtl/priority_queue_linear_scan_core.sv */
// ----------------------------------------------------------------------------
// priority_queue_linear_scan_core
// Bounded priority queue in a row of slot cells, kept in arrival order.
// Insert appends at the tail; extract scans for the greatest signed priority
// (oldest wins a tie), returns its value and shifts later slots down.
// ----------------------------------------------------------------------------
//  channel  signals                               direction
//  in       in_valid/in_ready, func, item_value,  into block
//           item_priority
//  out      out_valid/out_ready, out_value,       out of block
//           status, occupancy
//
//  Insert, full insert and empty extract: result in the cycle after acceptance.
//  Extract on a non-empty queue: the result waits for the scan token that
//  walks the cell row one slot per cycle; the shift-down lands with the result.
//  Input is taken when idle and the result register is empty or being taken.
//  Reset clears the entry count and the slot valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_queue_linear_scan_core #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               func,
	input  logic signed [pqls_pkg::DATA_W-1:0] item_value,
	input  logic signed [pqls_pkg::DATA_W-1:0] item_priority,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pqls_pkg::DATA_W-1:0] out_value,
	output logic [1:0]                         status,
	output logic [pqls_pkg::OCC_W-1:0]         occupancy
);
	import pqls_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic                     state_q;
	logic [CW-1:0]            count_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic [1:0]               status_q;
	logic [CW-1:0]            occ_q;

	logic                     accept;
	logic                     out_free;
	logic                     full;
	logic                     empty;
	logic                     scan_done;
	pqls_ctrl_t               ctrl;

	pqls_scan_t               scan   [DEPTH+1];
	logic [IW-1:0]            scan_idx [DEPTH+1];
	logic                     cell_valid [DEPTH];
	logic signed [DATA_W-1:0] cell_value [DEPTH];
	logic signed [DATA_W-1:0] cell_pri   [DEPTH];
	logic [DEPTH-1:0]         go_vec;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign scan_done = (state_q == S_SCAN) && scan[DEPTH].go;

	assign ctrl.ins   = accept && (func == FUNC_INSERT);
	assign ctrl.shift = scan_done;

	assign scan[0]     = {accept && (func == FUNC_EXTRACT) && !empty, 1'b0,
		{(2 * DATA_W){1'b0}}};
	assign scan_idx[0] = '0;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                     prev_v;
			logic                     next_v;
			logic signed [DATA_W-1:0] next_val;
			logic signed [DATA_W-1:0] next_pri;

			if (i == 0) begin : g_first
				assign prev_v = 1'b1;
			end else begin : g_mid
				assign prev_v = cell_valid[i-1];
			end

			if (i == DEPTH - 1) begin : g_last
				assign next_v   = 1'b0;
				assign next_val = '0;
				assign next_pri = '0;
			end else begin : g_inner
				assign next_v   = cell_valid[i+1];
				assign next_val = cell_value[i+1];
				assign next_pri = cell_pri[i+1];
			end

			pqls_cell #(
				.IW    (IW),
				.INDEX (i)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.ctrl          (ctrl),
				.shift_idx     (scan_idx[DEPTH]),
				.in_value      (item_value),
				.in_priority   (item_priority),
				.prev_valid    (prev_v),
				.next_valid    (next_v),
				.next_value    (next_val),
				.next_priority (next_pri),
				.scan_in       (scan[i]),
				.scan_in_idx   (scan_idx[i]),
				.scan_out      (scan[i+1]),
				.scan_out_idx  (scan_idx[i+1]),
				.valid         (cell_valid[i]),
				.value         (cell_value[i]),
				.prio          (cell_pri[i])
			);

			assign go_vec[i] = scan[i+1].go;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == FUNC_EXTRACT && !empty) begin
							state_q <= S_SCAN;
						end else begin
							out_valid_q <= 1'b1;
							if (func == FUNC_INSERT && !full) begin
								count_q <= count_q + CW'(1);
							end
						end
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						count_q     <= count_q - CW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (func == FUNC_INSERT) begin
				out_value_q <= '0;
				status_q    <= full ? ST_FULL : ST_OK;
				occ_q       <= full ? count_q : count_q + CW'(1);
			end else if (empty) begin
				out_value_q <= -32'sd1;
				status_q    <= ST_EMPTY;
				occ_q       <= count_q;
			end
		end else if (scan_done) begin
			out_value_q <= scan[DEPTH].val;
			status_q    <= ST_OK;
			occ_q       <= count_q - CW'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign status    = status_q;
	assign occupancy = OCC_W'(occ_q);

	// the scan token is in at most one cell
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(go_vec))
		else $error("more than one scan token in the cell row");

	// occupancy never exceeds the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	// a completed scan always found an entry
	a_scan_found: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> scan[DEPTH].found)
		else $error("extract scan ended without a candidate");

	// an insert into a non-full queue grows the count by one
	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.ins && !full) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not advance the entry count");

endmodule

`default_nettype wire
